@@ sv/crc_pkg.sv @@
// Shared types and constants for the bit-serial CRC encoder/checker.
package crc_pkg;

    localparam int DEF_MAX_DEGREE = 32;
    localparam int COEF_W         = 32;
    localparam int DEG_W          = 6;
    localparam int CFG_IDX_W      = 2;
    localparam int Q_DEPTH        = 4;

    localparam logic [COEF_W-1:0] GEN_LOW_RST = 32'd5;
    localparam logic [DEG_W-1:0]  GEN_DEG_RST = 6'd3;

    localparam logic [CFG_IDX_W-1:0] REG_GEN_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GEN_DEG = 2'd1;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_FLUSH = 2'd1,
        KIND_CHECK = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic             data_bit;
        logic             ok;
        logic [DEG_W-1:0] deg;
    } t_job;

endpackage

@@ sv/crc_front.sv @@
// Front end: configuration registers, remainder update and job classification.
module crc_front #(
    parameter int MAX_DEGREE = crc_pkg::DEF_MAX_DEGREE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [crc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [crc_pkg::COEF_W-1:0]   i_cfg_data,
    input  logic                         i_accept,
    input  logic                         i_data_bit,
    input  logic                         i_msg_last,
    input  logic                         i_op,
    output logic                         o_push,
    output crc_pkg::t_job                o_job,
    output logic [MAX_DEGREE-1:0]        o_snap
);
    import crc_pkg::*;

    localparam int IDX_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

    logic [COEF_W-1:0]     r_coef;
    logic [DEG_W-1:0]      r_deg;
    logic [MAX_DEGREE-1:0] r_rem;
    logic [MAX_DEGREE-1:0] n_rem;

    logic [DEG_W-1:0]      deg_eff;
    logic [DEG_W-1:0]      deg_m1;
    logic [DEG_W-1:0]      align_sh;
    logic [MAX_DEGREE-1:0] mask;
    logic [MAX_DEGREE-1:0] poly;
    logic [MAX_DEGREE-1:0] shl;
    logic [MAX_DEGREE-1:0] rem_calc;
    logic                  top;
    logic                  fb;

    always_comb begin
        if (r_deg == '0) begin
            deg_eff = DEG_W'(1);
        end else if (r_deg > DEG_W'(MAX_DEGREE)) begin
            deg_eff = DEG_W'(MAX_DEGREE);
        end else begin
            deg_eff = r_deg;
        end
        deg_m1 = deg_eff - DEG_W'(1);
        mask   = ~({MAX_DEGREE{1'b1}} << deg_eff);
        poly   = MAX_DEGREE'(r_coef) & mask;
        // remainder may carry stale bits above the degree after a degree change
        top    = r_rem[deg_m1[IDX_W-1:0]];
        shl    = r_rem << 1;
        if (i_op == OP_ENCODE) begin
            fb       = i_data_bit ^ top;
            rem_calc = (shl & mask) ^ (fb ? poly : '0);
        end else begin
            fb       = top;
            rem_calc = ((shl | MAX_DEGREE'(i_data_bit)) & mask) ^ (fb ? poly : '0);
        end
        n_rem    = i_msg_last ? '0 : rem_calc;
        // left-align so the back end always shifts out of the top bit
        align_sh = DEG_W'(MAX_DEGREE) - deg_eff;
        o_snap   = rem_calc << align_sh;

        o_job.data_bit = i_data_bit;
        o_job.ok       = (rem_calc == '0);
        o_job.deg      = deg_eff;
        if (i_op == OP_CHECK) begin
            o_job.kind = KIND_CHECK;
        end else if (i_msg_last) begin
            o_job.kind = KIND_FLUSH;
        end else begin
            o_job.kind = KIND_ECHO;
        end
        // check bits before the last one leave nothing to emit
        o_push = i_accept && (i_op == OP_ENCODE || i_msg_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= GEN_LOW_RST;
            r_deg  <= GEN_DEG_RST;
            r_rem  <= '0;
        end else begin
            if (i_accept) begin
                r_rem <= n_rem;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GEN_LOW: r_coef <= i_cfg_data;
                    REG_GEN_DEG: r_deg  <= i_cfg_data[DEG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ sv/crc_fifo.sv @@
// Short job queue between the front end and the back end.
module crc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = crc_pkg::Q_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;
    logic [CNT_W-1:0] n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

@@ sv/crc_back.sv @@
// Back end: turns queued jobs into result transfers, shifting out the remainder.
module crc_back #(
    parameter int MAX_DEGREE = crc_pkg::DEF_MAX_DEGREE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  crc_pkg::t_job         i_job,
    input  logic [MAX_DEGREE-1:0] i_snap,
    output logic                  o_q_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic                  o_code_bit,
    output logic                  o_run_last,
    output logic                  o_check_ok
);
    import crc_pkg::*;

    logic                  r_ovalid;
    logic                  r_code;
    logic                  r_last;
    logic                  r_ok;
    logic [MAX_DEGREE-1:0] r_shift;
    logic [DEG_W-1:0]      r_cnt;

    logic                  n_ovalid;
    logic                  n_code;
    logic                  n_last;
    logic                  n_ok;
    logic [MAX_DEGREE-1:0] n_shift;
    logic [DEG_W-1:0]      n_cnt;
    logic                  out_load;
    logic                  flushing;

    assign out_load = !r_ovalid || i_pop;
    assign flushing = (r_cnt != '0);

    always_comb begin
        n_ovalid = r_ovalid;
        n_code   = r_code;
        n_last   = r_last;
        n_ok     = r_ok;
        n_shift  = r_shift;
        n_cnt    = r_cnt;
        o_q_pop  = 1'b0;
        if (out_load) begin
            if (flushing) begin
                n_ovalid = 1'b1;
                n_code   = r_shift[MAX_DEGREE-1];
                n_last   = (r_cnt == DEG_W'(1));
                n_ok     = 1'b0;
                n_shift  = r_shift << 1;
                n_cnt    = r_cnt - DEG_W'(1);
            end else if (!i_q_empty) begin
                o_q_pop  = 1'b1;
                n_ovalid = 1'b1;
                case (i_job.kind)
                    KIND_ECHO: begin
                        n_code = i_job.data_bit;
                        n_last = 1'b0;
                        n_ok   = 1'b0;
                    end
                    KIND_FLUSH: begin
                        n_code  = i_job.data_bit;
                        n_last  = 1'b0;
                        n_ok    = 1'b0;
                        n_shift = i_snap;
                        n_cnt   = i_job.deg;
                    end
                    KIND_CHECK: begin
                        n_code = 1'b0;
                        n_last = 1'b1;
                        n_ok   = i_job.ok;
                    end
                    default: begin
                        n_ovalid = 1'b0;
                    end
                endcase
            end else begin
                n_ovalid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code  <= n_code;
        r_last  <= n_last;
        r_ok    <= n_ok;
        r_shift <= n_shift;
    end

    assign o_empty    = !r_ovalid;
    assign o_code_bit = r_code;
    assign o_run_last = r_last;
    assign o_check_ok = r_ok;

endmodule

@@ sv/crc_encode_check_bit_serial.sv @@
// Top level of the bit-serial CRC encoder/checker with configurable generator.
//
//  channel   | direction | transfer condition        | payload
//  ----------+-----------+---------------------------+----------------------------------
//  input     | in        | push && !full             | i_data_bit, i_msg_last, i_op
//  result    | out       | pop && !empty             | o_code_bit, o_run_last, o_check_ok
//  config    | in        | i_cfg_valid && o_cfg_ready| i_cfg_index, i_cfg_data
//
// One input bit per cycle while the job queue has room; the remainder LFSR step is combinational and registered.
// An encoded message adds D result bits (D = effective degree) for the remainder
// flush; the result side sets the sustained rate, input stalls once the job queue fills.
// A result reaches the ports through the queue write, then the output register load,
// and it can transfer once it sits in the output register.
// Synchronous active-low reset; no clearing pass, ready right after reset.
module crc_encode_check_bit_serial #(
    parameter int MAX_DEGREE = crc_pkg::DEF_MAX_DEGREE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_data_bit,
    input  logic                          i_msg_last,
    input  logic                          i_op,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_code_bit,
    output logic                          o_run_last,
    output logic                          o_check_ok,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [crc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [crc_pkg::COEF_W-1:0]    i_cfg_data
);
    import crc_pkg::*;

    localparam int QW = $bits(t_job) + MAX_DEGREE;

    logic                  accept;
    logic                  cfg_we;
    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_empty;
    t_job                  f_job;
    t_job                  b_job;
    logic [MAX_DEGREE-1:0] f_snap;
    logic [MAX_DEGREE-1:0] b_snap;
    logic [QW-1:0]         q_rdata;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign full        = q_full;
    assign accept      = push && !q_full;
    assign {b_snap, b_job} = q_rdata;

    crc_front #(.MAX_DEGREE(MAX_DEGREE)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_data_bit  (i_data_bit),
        .i_msg_last  (i_msg_last),
        .i_op        (i_op),
        .o_push      (q_push),
        .o_job       (f_job),
        .o_snap      (f_snap)
    );

    crc_fifo #(.W(QW), .DEPTH(Q_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata ({f_snap, f_job}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    crc_back #(.MAX_DEGREE(MAX_DEGREE)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_job      (b_job),
        .i_snap     (b_snap),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_code_bit (o_code_bit),
        .o_run_last (o_run_last),
        .o_check_ok (o_check_ok)
    );

endmodule

@@ sv/crc_chk.sv @@
// Port-level checker for the CRC block, bound to the top level.
module crc_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic full,
    input logic empty,
    input logic pop,
    input logic o_code_bit,
    input logic o_run_last,
    input logic o_check_ok
);

    // reset drains the result side and frees the input side
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full after reset");

    // a check verdict is always a lone, marked result with a zero code bit
    a_check_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_check_ok) |-> (o_run_last && !o_code_bit))
        else $error("check verdict without run_last or with code_bit set");

    // a waiting result stays put until it is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_code_bit) && $stable(o_run_last)
                              && $stable(o_check_ok)))
        else $error("stalled result changed");

endmodule

bind crc_encode_check_bit_serial crc_chk u_chk (.*);

@@ bench/crc_encode_check_bit_serial_tb.sv @@
// Testbench for the bit-serial CRC encoder/checker: directed table, a degree-change case, then random phases.
module crc_encode_check_bit_serial_tb;
    import crc_pkg::*;

    localparam int MAX_DEG      = DEF_MAX_DEGREE;
    localparam int SETTLE       = 8;
    localparam int LIMIT        = 400000;
    localparam int PHASE_ITEMS  = 12;
    localparam int NUM_PHASES   = 8;
    localparam int PRINT_CAP    = 50;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

    typedef struct packed {
        logic code_bit;
        logic run_last;
        logic check_ok;
    } t_crc_out;

    typedef struct packed {
        logic op;
        logic data_bit;
        logic msg_last;
        logic typed;
        logic ok;
    } t_row;

    typedef logic t_bits[$];

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 full;
    logic                 i_data_bit  = 1'b0;
    logic                 i_msg_last  = 1'b0;
    logic                 i_op        = 1'b0;
    logic                 empty;
    logic                 pop         = 1'b0;
    logic                 o_code_bit;
    logic                 o_run_last;
    logic                 o_check_ok;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COEF_W-1:0]    i_cfg_data  = '0;

    // predictor state
    logic [COEF_W-1:0] gen_coef = GEN_LOW_RST;
    logic [DEG_W-1:0]  gen_deg  = GEN_DEG_RST;
    logic [63:0]       crc_rem  = '0;

    t_crc_out crc_out_q[$];
    logic     codeword_q[$];

    int   tx_idle   = 0;
    int   rx_stall  = 0;
    int   item_cnt  = 0;
    int   error_cnt = 0;
    int   cycle_cnt = 0;
    logic seen_ok   = 1'b0;

    // reset generator 1101 unless written
    t_row dir_rows [19] = '{
        // lone one: echo, then remainder 101
        '{OP_ENCODE, 1'b1, 1'b1, 1'b0, 1'b0},
        // codeword 1101 divides cleanly
        '{OP_CHECK,  1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CHECK,  1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CHECK,  1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_CHECK,  1'b1, 1'b1, 1'b1, 1'b1},
        // codewords shorter than the degree are their own remainder
        '{OP_CHECK,  1'b1, 1'b1, 1'b1, 1'b0},
        '{OP_CHECK,  1'b0, 1'b1, 1'b1, 1'b1},
        '{OP_ENCODE, 1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_ENCODE, 1'b0, 1'b1, 1'b0, 1'b0},
        '{OP_ENCODE, 1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_ENCODE, 1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_ENCODE, 1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_ENCODE, 1'b1, 1'b1, 1'b0, 1'b0},
        // mixed ops: the last bit's op picks the result kind
        '{OP_ENCODE, 1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CHECK,  1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_ENCODE, 1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_CHECK,  1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_ENCODE, 1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_CHECK,  1'b1, 1'b1, 1'b0, 1'b0}
    };

    crc_encode_check_bit_serial u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data_bit  (i_data_bit),
        .i_msg_last  (i_msg_last),
        .i_op        (i_op),
        .empty       (empty),
        .pop         (pop),
        .o_code_bit  (o_code_bit),
        .o_run_last  (o_run_last),
        .o_check_ok  (o_check_ok),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic coin(input int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic flag_error(input string what);
        if (error_cnt < PRINT_CAP)
            $display("ERROR cycle %0d: %s", cycle_cnt, what);
        error_cnt++;
    endtask

    task automatic cmp_field(input string name, input logic got, input logic want);
        if (got !== want)
            flag_error($sformatf("%s got %b want %b", name, got, want));
    endtask

    // One bit through the divider; queues the results it causes.
    task automatic crc_shift(input logic b, input logic last, input logic op);
        int unsigned d;
        logic [63:0] mask;
        logic [63:0] poly;
        logic        top;
        t_crc_out    r;
        d = 32'(gen_deg);
        if (d < 1) d = 1;
        if (d > MAX_DEG) d = MAX_DEG;
        mask = (64'd1 << d) - 64'd1;
        poly = {32'd0, gen_coef} & mask;
        top  = crc_rem[d-1];
        if (op == OP_ENCODE) begin
            crc_rem = (crc_rem << 1) & mask;
            if (b ^ top) crc_rem ^= poly;
            r = '{b, 1'b0, 1'b0};
            crc_out_q.insert(crc_out_q.size(), r);
            codeword_q.insert(codeword_q.size(), b);
            if (last) begin
                for (int k = 0; k < int'(d); k++) begin
                    r = '{crc_rem[int'(d) - 1 - k], k == int'(d) - 1, 1'b0};
                    crc_out_q.insert(crc_out_q.size(), r);
                    codeword_q.insert(codeword_q.size(), r.code_bit);
                end
                crc_rem = '0;
            end
        end else begin
            crc_rem = ((crc_rem << 1) | {63'd0, b}) & mask;
            if (top) crc_rem ^= poly;
            if (last) begin
                r = '{1'b0, 1'b1, crc_rem == 64'd0};
                crc_out_q.insert(crc_out_q.size(), r);
                crc_rem = '0;
            end
        end
    endtask

    task automatic send_bit(input logic b, input logic last, input logic op);
        while ($urandom_range(0, 99) < tx_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_data_bit <= b;
        i_msg_last <= last;
        i_op       <= op;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        crc_shift(b, last, op);
        item_cnt++;
    endtask

    task automatic send_msg(input t_bits bits, input logic op);
        codeword_q.delete();
        foreach (bits[i])
            send_bit(bits[i], i == bits.size() - 1, op);
    endtask

    // leaves valid high so back-to-back writes need no gap
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        case (idx)
            REG_GEN_LOW: gen_coef = val;
            REG_GEN_DEG: gen_deg  = val[DEG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_gen(input logic [COEF_W-1:0] coef, input logic [COEF_W-1:0] deg_word);
        cfg_write(REG_GEN_LOW, coef);
        cfg_write(REG_GEN_DEG, deg_word);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop sending, let every expected result out, then allow check-mode bits to settle.
    task automatic drain();
        push <= 1'b0;
        while (crc_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_message();
        int     pick;
        int     len;
        int     flip;
        t_bits  msg_bits;
        t_bits  cw;
        pick = $urandom_range(0, 99);
        len  = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) msg_bits.insert(msg_bits.size(), coin(50));
        if (pick < 50) begin
            // encode, then feed the codeword back, sometimes with one bit flipped
            send_msg(msg_bits, OP_ENCODE);
            cw = codeword_q;
            if (coin(30)) begin
                flip = $urandom_range(0, cw.size() - 1);
                cw[flip] = ~cw[flip];
            end
            send_msg(cw, OP_CHECK);
        end else if (pick < 70) begin
            send_msg(msg_bits, OP_ENCODE);
        end else if (pick < 85) begin
            send_msg(msg_bits, OP_CHECK);
        end else begin
            for (int i = 0; i < len; i++) send_bit(coin(50), coin(25), coin(50));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= $urandom_range(0, 99) >= rx_stall;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_crc_out want;
        if (i_rst_n && pop && !empty) begin
            if (o_run_last === 1'b1) seen_ok = o_check_ok;
            if (crc_out_q.size() == 0) begin
                flag_error($sformatf("result with nothing expected: %b %b %b",
                                     o_code_bit, o_run_last, o_check_ok));
            end else begin
                want = crc_out_q.pop_front();
                cmp_field("code_bit", o_code_bit, want.code_bit);
                cmp_field("run_last", o_run_last, want.run_last);
                cmp_field("check_ok", o_check_ok, want.check_ok);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("timeout with %0d results outstanding", crc_out_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        logic [COEF_W-1:0] coef;
        logic [COEF_W-1:0] deg_word;
        int                phase_end;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset generator, no writes yet
        foreach (dir_rows[i]) begin
            send_bit(dir_rows[i].data_bit, dir_rows[i].msg_last, dir_rows[i].op);
            if (dir_rows[i].typed) begin
                drain();
                if (seen_ok !== dir_rows[i].ok)
                    flag_error($sformatf("row %0d check_ok got %b want %b", i, seen_ok,
                                         dir_rows[i].ok));
            end
        end

        // degree change in the middle of a message, and writes to unused indexes
        send_bit(1'b1, 1'b0, OP_ENCODE);
        send_bit(1'b0, 1'b0, OP_ENCODE);
        drain();
        cfg_write(REG_GEN_DEG, 32'd5);
        cfg_write(REG_UNUSED_A, '1);
        cfg_write(REG_UNUSED_B, '1);
        i_cfg_valid <= 1'b0;
        send_bit(1'b1, 1'b1, OP_ENCODE);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            case (ph)
                0: begin coef = '1;            deg_word = 32'd32;                      end
                1: begin coef = '0;            deg_word = 32'd1;                       end
                2: begin coef = $urandom();    deg_word = $urandom() & 32'hFFFF_FFC0;  end
                3: begin coef = $urandom();    deg_word = '1;                          end
                4: begin coef = 32'h04C1_1DB7; deg_word = 32'd32;                      end
                5: begin coef = $urandom();    deg_word = $urandom_range(2, 16);       end
                6: begin coef = 32'h0000_1021; deg_word = 32'hFFFF_FFD0;               end
                default: begin
                    coef     = $urandom();
                    deg_word = ($urandom() & 32'hFFFF_FFC0) | $urandom_range(33, 62);
                end
            endcase
            program_gen(coef, deg_word);
            case (ph % 4)
                0: begin tx_idle = 0;  rx_stall = 0;  end
                1: begin tx_idle = 62; rx_stall = 0;  end
                2: begin tx_idle = 0;  rx_stall = 62; end
                default: begin tx_idle = 15; rx_stall = 15; end
            endcase
            phase_end = item_cnt + PHASE_ITEMS;
            while (item_cnt < phase_end) run_message();
        end

        drain();
        if (error_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
